@@ rtl/core/sdfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sigma-delta frequency dither package
// Shared sizes, the frequency level table and the divider request type.
// ----------------------------------------------------------------------------
package sdfd_pkg;

    localparam int NUM_LEVELS     = 8;
    localparam int ACC_FRAC_BITS  = 16;
    localparam int FREQ_FRAC_BITS = 8;

    localparam int LEVEL_W  = 10;
    localparam int TARGET_W = LEVEL_W + FREQ_FRAC_BITS;
    localparam int ACC_W    = ACC_FRAC_BITS + 1;
    localparam int IDX_W    = $clog2(NUM_LEVELS);
    localparam int CNT_W    = $clog2(ACC_FRAC_BITS + 1);

    localparam logic [LEVEL_W-1:0] LEVEL_TABLE [NUM_LEVELS] = '{
        10'd1020, 10'd918, 10'd816, 10'd714, 10'd612, 10'd510, 10'd408, 10'd306
    };

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 10'd918;

    function automatic logic [TARGET_W-1:0] to_q(input logic [LEVEL_W-1:0] level);
        to_q = TARGET_W'(level) << FREQ_FRAC_BITS;
    endfunction

    localparam logic [TARGET_W-1:0] TOP_Q    = to_q(LEVEL_TABLE[0]);
    localparam logic [TARGET_W-1:0] BOT_Q    = to_q(LEVEL_TABLE[NUM_LEVELS-1]);
    localparam logic [TARGET_W-1:0] RESET_Q  = to_q(LEVEL_RESET);

    typedef struct packed {
        logic                start;
        logic [TARGET_W-1:0] dividend;
        logic [TARGET_W-1:0] divisor;
    } div_req_t;

endpackage
`default_nettype wire

@@ rtl/core/sdfd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sigma-delta frequency dither channels
// Valid/ready channels for the tick input and the level result.
// ----------------------------------------------------------------------------
interface sdfd_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface sdfd_level_if;
    import sdfd_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] selected_freq_mhz;
    logic               chose_upper;
    logic               pinned;

    modport source (output valid, output selected_freq_mhz, output chose_upper,
                    output pinned, input ready);
    modport sink (input valid, input selected_freq_mhz, input chose_upper,
                  input pinned, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sdfd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sigma-delta frequency dither serial divider
// Restoring divider that yields one fraction bit per cycle.
// ----------------------------------------------------------------------------
module sdfd_div
    import sdfd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire div_req_t                 req,
    output logic                          done,
    output logic [ACC_FRAC_BITS-1:0]      quotient
);

    logic [TARGET_W-1:0]      rem_reg, rem_next;
    logic [TARGET_W-1:0]      den_reg;
    logic [ACC_FRAC_BITS-1:0] q_reg, q_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [TARGET_W:0]        shifted;
    logic                     take;

    assign shifted = {rem_reg, 1'b0};
    assign take    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend;
            q_next    = '0;
            cnt_next  = CNT_W'(ACC_FRAC_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = take ? TARGET_W'(shifted - {1'b0, den_reg}) : TARGET_W'(shifted);
            q_next   = {q_reg[ACC_FRAC_BITS-2:0], take};
            cnt_next = CNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (req.start)
        begin
            den_reg <= req.divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

@@ rtl/core/sigma_delta_freq_dither.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sigma-delta frequency dither
// Issues one table frequency level per tick, dithering between two levels.
// ----------------------------------------------------------------------------
// Each accepted transfer with tick set yields one level; tick clear yields
// none. A pinned target's level goes to the result registers and then to the
// output register. Otherwise a sequencer walks the level table one entry per
// cycle to find the bracket, then a serial divider produces the sixteen
// fraction bits one per cycle; the input is not ready until the result has
// moved to the output register, where it waits while the next tick is taken.
// A configuration write saturates the target and clears the accumulator.
module sigma_delta_freq_dither
    import sdfd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [TARGET_W-1:0] cfg_wdata,
    sdfd_tick_if.sink                tick_ch,
    sdfd_level_if.source             level_ch
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [LEVEL_W-1:0]  prev_lower_reg, prev_lower_next;
    logic [LEVEL_W-1:0]  prev_upper_reg, prev_upper_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [LEVEL_W-1:0]  lower_reg, lower_next;
    logic [LEVEL_W-1:0]  upper_reg, upper_next;
    logic [LEVEL_W-1:0]  res_level_reg, res_level_next;
    logic                res_upper_reg, res_upper_next;
    logic                res_pinned_reg, res_pinned_next;
    logic                out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic                out_upper_reg;
    logic                out_pinned_reg;

    logic                in_xfer;
    logic                at_top;
    logic                at_bot;
    logic                out_free;
    logic                load_out;
    logic [LEVEL_W-1:0]  cand_level;
    logic [LEVEL_W-1:0]  cand_upper;
    logic                found;
    logic [ACC_W-1:0]    acc_sum;
    logic [TARGET_W-1:0] cfg_sat;
    div_req_t            div_req;
    logic                div_done;
    logic [ACC_FRAC_BITS-1:0] div_q;

    assign in_xfer    = tick_ch.valid && tick_ch.ready;
    assign at_top     = target_reg >= TOP_Q;
    assign at_bot     = target_reg <= BOT_Q;
    assign out_free   = !out_valid_reg || level_ch.ready;
    assign load_out   = (state_reg == S_EMIT) && out_free;
    assign cand_level = LEVEL_TABLE[idx_reg];
    assign cand_upper = LEVEL_TABLE[IDX_W'(idx_reg - 1'b1)];
    assign found      = (to_q(cand_level) <= target_reg) ||
                        (idx_reg == IDX_W'(NUM_LEVELS - 1));
    assign acc_sum    = ACC_W'(acc_reg + ACC_W'(div_q));
    assign cfg_sat    = (cfg_wdata < BOT_Q) ? BOT_Q :
                        (cfg_wdata > TOP_Q) ? TOP_Q : cfg_wdata;

    assign div_req.start    = (state_reg == S_SEARCH) && found;
    assign div_req.dividend = TARGET_W'(target_reg - to_q(cand_level));
    assign div_req.divisor  = to_q(LEVEL_W'(cand_upper - cand_level));

    sdfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        target_next     = target_reg;
        acc_next        = acc_reg;
        prev_lower_next = prev_lower_reg;
        prev_upper_next = prev_upper_reg;
        idx_next        = idx_reg;
        lower_next      = lower_reg;
        upper_next      = upper_reg;
        res_level_next  = res_level_reg;
        res_upper_next  = res_upper_reg;
        res_pinned_next = res_pinned_reg;
        out_valid_next  = out_valid_reg;

        if (level_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && tick_ch.tick)
                begin
                    if (at_top || at_bot)
                    begin
                        res_level_next  = at_top ? LEVEL_TABLE[0] : LEVEL_TABLE[NUM_LEVELS-1];
                        res_upper_next  = 1'b0;
                        res_pinned_next = 1'b1;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(1);
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (found)
                begin
                    lower_next = cand_level;
                    upper_next = cand_upper;
                    if (cand_level != prev_lower_reg || cand_upper != prev_upper_reg)
                    begin
                        acc_next        = '0;
                        prev_lower_next = cand_level;
                        prev_upper_next = cand_upper;
                    end
                    state_next = S_DIVIDE;
                end
                else
                begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    res_pinned_next = 1'b0;
                    res_upper_next  = acc_sum[ACC_FRAC_BITS];
                    res_level_next  = acc_sum[ACC_FRAC_BITS] ? upper_reg : lower_reg;
                    acc_next        = {1'b0, acc_sum[ACC_FRAC_BITS-1:0]};
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            target_next     = cfg_sat;
            acc_next        = '0;
            prev_lower_next = '0;
            prev_upper_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            target_reg     <= RESET_Q;
            acc_reg        <= '0;
            prev_lower_reg <= '0;
            prev_upper_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            target_reg     <= target_next;
            acc_reg        <= acc_next;
            prev_lower_reg <= prev_lower_next;
            prev_upper_reg <= prev_upper_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        lower_reg      <= lower_next;
        upper_reg      <= upper_next;
        res_level_reg  <= res_level_next;
        res_upper_reg  <= res_upper_next;
        res_pinned_reg <= res_pinned_next;
        if (load_out)
        begin
            out_level_reg  <= res_level_reg;
            out_upper_reg  <= res_upper_reg;
            out_pinned_reg <= res_pinned_reg;
        end
    end

    assign tick_ch.ready              = (state_reg == S_IDLE);
    assign level_ch.valid             = out_valid_reg;
    assign level_ch.selected_freq_mhz = out_level_reg;
    assign level_ch.chose_upper       = out_upper_reg;
    assign level_ch.pinned            = out_pinned_reg;

`ifndef SYNTHESIS
    // The accumulator never holds a value of one or more between ticks.
    assert property (@(posedge clk) disable iff (!rst_n)
        !acc_reg[ACC_FRAC_BITS])
        else $error("accumulator left at or above one");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside the divide phase");

    // A tick with the target strictly inside the table starts a bracket search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && tick_ch.tick && !at_top && !at_bot) |=> (state_reg == S_SEARCH))
        else $error("inner target did not start a search");

    // A pinned result never reports an upper choice.
    assert property (@(posedge clk) disable iff (!rst_n)
        level_ch.valid |-> !(level_ch.pinned && level_ch.chose_upper))
        else $error("pinned result flagged as upper choice");
`endif

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigma-delta frequency dither testbench
// Drives ticks and target-frequency writes into the dither block with random
// gaps and stalls. Every accepted tick is run through a bit-exact predictor,
// and each level transfer is checked in order against it.
// ----------------------------------------------------------------------------
module testbench;
    import sdfd_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] freq_mhz;
        logic               chose_upper;
        logic               pinned;
    } level_result_t;

    class dither_scoreboard;
        logic [TARGET_W-1:0] target_q;
        logic [ACC_W-1:0]    frac_acc;
        logic [LEVEL_W:0]    bracket_lower;
        logic [LEVEL_W:0]    bracket_upper;
        level_result_t       expected_levels[$];
        int                  errors;

        function new();
            target_q = RESET_Q;
            frac_acc = '0;
            bracket_lower = '0;
            bracket_upper = '0;
            errors = 0;
        endfunction

        function void write_target(input logic [TARGET_W-1:0] value);
            if (value < BOT_Q)
                target_q = BOT_Q;
            else if (value > TOP_Q)
                target_q = TOP_Q;
            else
                target_q = value;
            frac_acc = '0;
            bracket_lower = '0;
            bracket_upper = '0;
        endfunction

        function void take_tick(input logic tick);
            level_result_t      r;
            logic [IDX_W-1:0]   idx;
            logic [LEVEL_W-1:0] lower;
            logic [LEVEL_W-1:0] upper;
            logic [47:0]        num;
            logic [47:0]        den;
            logic [47:0]        frac;
            logic [47:0]        sum;
            bit                 found;

            if (!tick)
                return;
            r = '0;
            if (target_q >= TOP_Q || target_q <= BOT_Q)
            begin
                r.freq_mhz = (target_q >= TOP_Q) ? LEVEL_TABLE[0] : LEVEL_TABLE[NUM_LEVELS-1];
                r.pinned = 1'b1;
            end
            else
            begin
                idx = IDX_W'(NUM_LEVELS - 1);
                found = 1'b0;
                for (int i = 1; i < NUM_LEVELS; i++)
                begin
                    if (!found &&
                        ((48'(LEVEL_TABLE[IDX_W'(i)]) << FREQ_FRAC_BITS) <= 48'(target_q)))
                    begin
                        idx = IDX_W'(i);
                        found = 1'b1;
                    end
                end
                lower = LEVEL_TABLE[idx];
                upper = LEVEL_TABLE[IDX_W'(idx - 1'b1)];
                if ({1'b0, lower} != bracket_lower || {1'b0, upper} != bracket_upper)
                begin
                    frac_acc = '0;
                    bracket_lower = {1'b0, lower};
                    bracket_upper = {1'b0, upper};
                end
                num = (48'(target_q) - (48'(lower) << FREQ_FRAC_BITS)) << ACC_FRAC_BITS;
                den = (48'(upper) - 48'(lower)) << FREQ_FRAC_BITS;
                frac = (den != 48'd0) ? num / den : 48'd0;
                if (frac >= (48'd1 << ACC_FRAC_BITS))
                    frac = (48'd1 << ACC_FRAC_BITS) - 48'd1;
                sum = 48'(frac_acc) + frac;
                frac_acc = sum[ACC_W-1:0];
                if (frac_acc[ACC_FRAC_BITS])
                begin
                    frac_acc[ACC_FRAC_BITS] = 1'b0;
                    r.freq_mhz = upper;
                    r.chose_upper = 1'b1;
                end
                else
                begin
                    r.freq_mhz = lower;
                end
            end
            expected_levels.insert(expected_levels.size(), r);
        endfunction

        function void check_level(input level_result_t got);
            level_result_t want;

            if (expected_levels.size() == 0)
            begin
                errors++;
                $display("%0t: level transfer expected none actual freq %0d upper %0b pinned %0b",
                         $time, got.freq_mhz, got.chose_upper, got.pinned);
                return;
            end
            want = expected_levels.pop_front();
            if (got.freq_mhz !== want.freq_mhz)
            begin
                errors++;
                $display("%0t: selected_freq_mhz expected %0d actual %0d",
                         $time, want.freq_mhz, got.freq_mhz);
            end
            if (got.chose_upper !== want.chose_upper)
            begin
                errors++;
                $display("%0t: chose_upper expected %0b actual %0b",
                         $time, want.chose_upper, got.chose_upper);
            end
            if (got.pinned !== want.pinned)
            begin
                errors++;
                $display("%0t: pinned expected %0b actual %0b",
                         $time, want.pinned, got.pinned);
            end
        endfunction
    endclass

    localparam int SETTLE_CYCLES = 40;
    localparam int TICK_GOAL     = 1250;

    localparam logic [TARGET_W-1:0] CORNER_TARGETS [8] = '{
        18'd0, 18'h3FFFF, 18'd261120, 18'd78336,
        18'd261119, 18'd78337, 18'd182784, 18'd169728
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [TARGET_W-1:0] cfg_wdata;

    sdfd_tick_if  tick_ch ();
    sdfd_level_if level_ch ();

    sigma_delta_freq_dither dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .tick_ch   (tick_ch),
        .level_ch  (level_ch)
    );

    dither_scoreboard sb;
    bit               calm;
    int               ticks_sent;
    int               levels_seen;
    bit               long_hold_done;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;

        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_tick(input logic tick);
        tick_ch.valid <= 1'b1;
        tick_ch.tick <= tick;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        sb.take_tick(tick);
        if (tick)
            ticks_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        tick_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        while (sb.expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input logic [TARGET_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_target(value);
    endtask

    task automatic send_random_ticks(input int count);
        int gap;

        for (int n = 0; n < count; n++)
        begin
            send_tick(($urandom_range(0, 24) != 0) ? 1'b1 : 1'b0);
            gap = pick_gap();
            if (gap != 0)
                pause_sender(gap);
        end
    endtask

    function automatic logic [TARGET_W-1:0] random_target();
        int               r;
        logic [IDX_W-1:0] pick;

        r = $urandom_range(0, 99);
        if (r < 80)
            return TARGET_W'($urandom_range(int'(BOT_Q) + 1, int'(TOP_Q) - 1));
        if (r < 90)
            return TARGET_W'($urandom);
        pick = IDX_W'($urandom_range(0, NUM_LEVELS - 1));
        return TARGET_W'(LEVEL_TABLE[pick]) << FREQ_FRAC_BITS;
    endfunction

    initial
    begin
        level_ch.ready <= 1'b0;
        levels_seen = 0;
        long_hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            int gap;
            level_result_t got;

            if (!long_hold_done && levels_seen >= 150 && tick_ch.valid)
            begin
                gap = 300;
                long_hold_done = 1'b1;
            end
            else
            begin
                gap = pick_gap();
            end
            if (gap != 0)
            begin
                level_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            level_ch.ready <= 1'b1;
            @(posedge clk);
            while (!level_ch.valid)
                @(posedge clk);
            got.freq_mhz = level_ch.selected_freq_mhz;
            got.chose_upper = level_ch.chose_upper;
            got.pinned = level_ch.pinned;
            sb.check_level(got);
            levels_seen++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        sb = new();
        calm = 1'b0;
        ticks_sent = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.tick <= 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset target sits exactly on an inner level.
        send_tick(1'b1);
        send_tick(1'b1);
        for (int c = 0; c < 8; c++)
        begin
            write_target(CORNER_TARGETS[c]);
            send_tick(1'b1);
            if (c % 3 == 0)
                send_tick(1'b0);
            send_tick(1'b1);
            if (c >= 4)
                send_tick(1'b1);
        end

        while (ticks_sent < TICK_GOAL)
        begin
            write_target(random_target());
            calm = ($urandom_range(0, 3) == 0);
            send_random_ticks($urandom_range(20, 80));
        end

        wait_drained();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
